>>> design/prt_pkg.sv
// Shared types, codes and widths of the pencil rank/tuple mapper.
`default_nettype none
package prt_pkg;

    localparam int unsigned REG_W   = 13;
    localparam int unsigned RANK_W  = 24;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned PROD_W  = 2 * REG_W;
    localparam int unsigned IDX_W   = 3;

    typedef enum logic [2:0] {
        FN_RANK_X  = 3'd0,
        FN_RANK_Y  = 3'd1,
        FN_RANK_Z  = 3'd2,
        FN_TUPLE_X = 3'd3,
        FN_TUPLE_Y = 3'd4,
        FN_TUPLE_Z = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_RATIO  = 2'd1,
        ERR_EXTENT = 2'd2
    } err_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_GRID2D_X = 3'd0,
        CFG_GRID2D_Y = 3'd1,
        CFG_GRID2D_Z = 3'd2,
        CFG_GRID3D_X = 3'd3,
        CFG_GRID3D_Y = 3'd4,
        CFG_GRID3D_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        func_t               func;
        logic [RANK_W-1:0]   rank;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        err_t                err;
        logic                zero;
    } base_t;

    typedef struct packed {
        base_t               base;
        logic [REG_W-1:0]    pc;
        logic [REG_W-1:0]    pr;
        logic [PROD_W-1:0]   span;
        logic [RANK_W-1:0]   ncpc;
    } b_side_t;

    typedef struct packed {
        b_side_t             bs;
        logic [RANK_W-1:0]   d1q;
        logic [RANK_W-1:0]   d1r;
        logic [RANK_W-1:0]   d2q;
        logic [RANK_W-1:0]   d2r;
        logic [RANK_W-1:0]   d3r;
    } c_side_t;

endpackage
`default_nettype wire

>>> design/prt_divider.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none
module prt_divider #(
    parameter int unsigned LANES = 1,
    parameter int unsigned DW    = 24,
    parameter int unsigned VW    = 24,
    parameter int unsigned SW    = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [SW-1:0]               in_side,
    input  wire logic [LANES-1:0][DW-1:0]    dividend,
    input  wire logic [LANES-1:0][VW-1:0]    divisor,
    output logic                             out_valid,
    output logic [SW-1:0]                    out_side,
    output logic [LANES-1:0][DW-1:0]         quot,
    output logic [LANES-1:0][VW-1:0]         rem
);

    logic [LANES-1:0][VW-1:0] rem_reg  [DW];
    logic [LANES-1:0][DW-1:0] quo_reg  [DW];
    logic [LANES-1:0][VW-1:0] dvs_reg  [DW];
    logic [SW-1:0]            side_reg [DW];
    logic [DW-1:0]            vld_reg;

    logic [LANES-1:0][VW-1:0] src_rem  [DW];
    logic [LANES-1:0][DW-1:0] src_quo  [DW];
    logic [LANES-1:0][VW-1:0] src_dvs  [DW];
    logic [LANES-1:0][VW-1:0] rem_next [DW];
    logic [LANES-1:0][DW-1:0] quo_next [DW];

    for (genvar k = 0; k < DW; k++) begin : g_src
        if (k == 0) begin : g_first
            assign src_rem[k] = '0;
            assign src_quo[k] = dividend;
            assign src_dvs[k] = divisor;
        end else begin : g_rest
            assign src_rem[k] = rem_reg[k-1];
            assign src_quo[k] = quo_reg[k-1];
            assign src_dvs[k] = dvs_reg[k-1];
        end
    end

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb
    begin
        logic [VW:0] trial;
        logic        ge;
        for (int k = 0; k < DW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {src_rem[k][l], src_quo[k][l][DW-1]};
                ge    = (trial >= {1'b0, src_dvs[k][l]});
                rem_next[k][l] = ge ? VW'(trial - {1'b0, src_dvs[k][l]})
                                    : trial[VW-1:0];
                quo_next[k][l] = {src_quo[k][l][DW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < DW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < DW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= src_dvs[k];
            end
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign out_side  = side_reg[DW-1];
    assign quot      = quo_reg[DW-1];
    assign rem       = rem_reg[DW-1];

endmodule
`default_nettype wire

>>> design/pencil_rank_tuple_mapper_unit.sv
// Top level of the pencil rank/tuple mapper: config, divider chain, arithmetic.
//
// Maps pencil grid tuples to ranks and ranks back to tuples for a pencil
// decomposition laid inside a block decomposition. Write the six grid
// registers through the cfg channel while the pipeline is empty; then stream
// items. One item is accepted every cycle unless a stall on m_tready holds
// the pipe, and each gives exactly one result. The pipeline is built from
// three chained restoring dividers that retire one quotient bit per stage:
// 13 stages for the pencil-per-cube ratios, 24 stages for the first-level
// quotients and 24 for the second-level ones, plus one stage of multipliers
// after the ratios, one of products before the final adds and the output
// register. A stall on m_tready freezes the pipe as a whole, but a bubble in
// front of the held output is still filled, so input is taken while a result
// waits. An error result carries zero rank and coordinates.
`default_nettype none
module pencil_rank_tuple_mapper_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // rank_in[23:0] coord_x coord_y coord_z, pad
    input  wire logic [2:0]  s_tuser,   // func[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0] m_tdata         // rank_out out_x out_y out_z error[1:0], pad
);

    localparam int unsigned RW = prt_pkg::REG_W;
    localparam int unsigned NW = prt_pkg::RANK_W;
    localparam int unsigned CW = prt_pkg::COORD_W;
    localparam int unsigned PW = prt_pkg::PROD_W;

    function automatic logic [NW-1:0] mul_lo(input logic [NW-1:0] a,
                                             input logic [NW-1:0] b);
        logic [2*NW-1:0] full;
        full = a * b;
        return full[NW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [RW-1:0] g2x_reg, g2y_reg, g2z_reg, g3x_reg, g3y_reg, g3z_reg;
    logic [PW-1:0] nc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g2x_reg <= RW'(1);
            g2y_reg <= RW'(1);
            g2z_reg <= RW'(1);
            g3x_reg <= RW'(1);
            g3y_reg <= RW'(1);
            g3z_reg <= RW'(1);
        end
        else if (cfg_valid)
        begin
            case (prt_pkg::cfg_idx_t'(cfg_index))
                prt_pkg::CFG_GRID2D_X: g2x_reg <= cfg_data;
                prt_pkg::CFG_GRID2D_Y: g2y_reg <= cfg_data;
                prt_pkg::CFG_GRID2D_Z: g2z_reg <= cfg_data;
                prt_pkg::CFG_GRID3D_X: g3x_reg <= cfg_data;
                prt_pkg::CFG_GRID3D_Y: g3y_reg <= cfg_data;
                prt_pkg::CFG_GRID3D_Z: g3z_reg <= cfg_data;
                default: ;  // drop writes outside the register list
            endcase
        end
    end

    // block count of one column of cubes, follows the config registers
    always_ff @(posedge clk)
    begin
        nc_reg <= g3z_reg * g3y_reg;
    end

    // ---------------- pipeline control ----------------
    logic out_vld_reg;
    logic m_vld_reg;
    logic en;
    logic out_en;

    // advance whenever the output can take a result or the slot ahead of it is empty
    assign out_en   = m_tready | ~out_vld_reg;
    assign en       = out_en | ~m_vld_reg;
    assign s_tready = en;

    // ---------------- input decode and error check ----------------
    prt_pkg::func_t func_in;
    prt_pkg::base_t base_in;
    logic [RW-1:0]  pcn, pcd, prn, prd, pax;
    logic           op_ok;
    logic           tuple_op;

    assign func_in  = prt_pkg::func_t'(s_tuser);
    assign tuple_op = func_in inside {prt_pkg::FN_TUPLE_X, prt_pkg::FN_TUPLE_Y,
                                      prt_pkg::FN_TUPLE_Z};

    always_comb
    begin
        op_ok = 1'b1;
        pcn = g2y_reg; pcd = g3y_reg; prn = g2z_reg; prd = g3z_reg; pax = g2x_reg;
        case (func_in)
            prt_pkg::FN_RANK_X, prt_pkg::FN_TUPLE_X:
            begin
                pcn = g2y_reg; pcd = g3y_reg; prn = g2z_reg; prd = g3z_reg;
                pax = g2x_reg;
            end
            prt_pkg::FN_RANK_Y, prt_pkg::FN_TUPLE_Y:
            begin
                pcn = g2x_reg; pcd = g3x_reg; prn = g2z_reg; prd = g3z_reg;
                pax = g2y_reg;
            end
            prt_pkg::FN_RANK_Z, prt_pkg::FN_TUPLE_Z:
            begin
                pcn = g2y_reg; pcd = g3y_reg; prn = g2x_reg; prd = g3x_reg;
                pax = g2z_reg;
            end
            default: op_ok = 1'b0;
        endcase

        base_in.func = func_in;
        base_in.rank = s_tdata[23:0];
        base_in.cx   = s_tdata[35:24];
        base_in.cy   = s_tdata[47:36];
        base_in.cz   = s_tdata[59:48];
        // extent first, then zero block counts, then a ratio below one
        if (!op_ok)
            base_in.err = prt_pkg::ERR_NONE;
        else if (tuple_op && pax != RW'(1))
            base_in.err = prt_pkg::ERR_EXTENT;
        else if (g3x_reg == '0 || g3y_reg == '0 || g3z_reg == '0 ||
                 pcn < pcd || prn < prd)
            base_in.err = prt_pkg::ERR_RATIO;
        else
            base_in.err = prt_pkg::ERR_NONE;
        base_in.zero = !op_ok || (base_in.err != prt_pkg::ERR_NONE);
    end

    // ---------------- ratios: pc = pcn / pcd, pr = prn / prd ----------------
    logic                 a_vld;
    prt_pkg::base_t       a_base;
    logic [1:0][RW-1:0]   a_quot;

    prt_divider #(
        .LANES (2),
        .DW    (RW),
        .VW    (RW),
        .SW    ($bits(prt_pkg::base_t))
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_side   (base_in),
        .dividend  ({prn, pcn}),
        .divisor   ({prd, pcd}),
        .out_valid (a_vld),
        .out_side  (a_base),
        .quot      (a_quot),
        .rem       ()
    );

    // ---------------- products of the ratios ----------------
    logic            p_vld_reg;
    prt_pkg::b_side_t p_side_reg;
    logic [2*NW-1:0] ncpc_full;

    assign ncpc_full = {{NW{1'b0}}, nc_reg[NW-1:0]} * {{(2*NW-RW){1'b0}}, a_quot[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= a_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg.base <= a_base;
            p_side_reg.pc   <= a_quot[0];
            p_side_reg.pr   <= a_quot[1];
            p_side_reg.span <= g2y_reg * a_quot[1];
            p_side_reg.ncpc <= ncpc_full[NW-1:0];
        end
    end

    // ---------------- first-level quotients ----------------
    logic [2:0][NW-1:0] b_num;
    logic [2:0][PW-1:0] b_den;

    always_comb
    begin
        b_num = '0;
        b_den = {PW'(1), PW'(1), PW'(1)};
        case (p_side_reg.base.func)
            prt_pkg::FN_RANK_X:
            begin
                b_num[0] = NW'(p_side_reg.base.cy); b_den[0] = PW'(p_side_reg.pc);
                b_num[1] = NW'(p_side_reg.base.cz); b_den[1] = PW'(p_side_reg.pr);
            end
            prt_pkg::FN_RANK_Y:
            begin
                b_num[1] = NW'(p_side_reg.base.cz); b_den[1] = PW'(p_side_reg.pr);
            end
            prt_pkg::FN_RANK_Z:
            begin
                b_num[0] = NW'(p_side_reg.base.cy); b_den[0] = PW'(p_side_reg.pc);
                b_num[1] = NW'(p_side_reg.base.cx); b_den[1] = PW'(p_side_reg.pr);
            end
            prt_pkg::FN_TUPLE_X:
            begin
                b_num[0] = p_side_reg.base.rank; b_den[0] = nc_reg;
            end
            prt_pkg::FN_TUPLE_Y:
            begin
                b_num[0] = p_side_reg.base.rank; b_den[0] = PW'(g2z_reg);
            end
            prt_pkg::FN_TUPLE_Z:
            begin
                b_num[0] = p_side_reg.base.rank; b_den[0] = p_side_reg.span;
                b_num[1] = p_side_reg.base.rank; b_den[1] = PW'(g3z_reg);
                b_num[2] = p_side_reg.base.rank; b_den[2] = PW'(p_side_reg.pc);
            end
            default: ;
        endcase
    end

    logic               b_vld;
    prt_pkg::b_side_t   b_side;
    logic [2:0][NW-1:0] b_quot;
    logic [2:0][PW-1:0] b_rem;

    prt_divider #(
        .LANES (3),
        .DW    (NW),
        .VW    (PW),
        .SW    ($bits(prt_pkg::b_side_t))
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_vld_reg),
        .in_side   (p_side_reg),
        .dividend  (b_num),
        .divisor   (b_den),
        .out_valid (b_vld),
        .out_side  (b_side),
        .quot      (b_quot),
        .rem       (b_rem)
    );

    // ---------------- second-level quotients ----------------
    prt_pkg::c_side_t   c_in;
    logic [1:0][NW-1:0] c_num;
    logic [1:0][RW-1:0] c_den;

    always_comb
    begin
        // remainders never exceed their dividend, which fits in a rank
        c_in.bs  = b_side;
        c_in.d1q = b_quot[0];
        c_in.d1r = b_rem[0][NW-1:0];
        c_in.d2q = b_quot[1];
        c_in.d2r = b_rem[1][NW-1:0];
        c_in.d3r = b_rem[2][NW-1:0];
        c_num[0] = b_rem[0][NW-1:0];
        c_den[0] = g3z_reg;
        c_den[1] = b_side.pc;
        if (b_side.base.func == prt_pkg::FN_TUPLE_Z)
            c_num[1] = b_rem[1][NW-1:0];
        else
            c_num[1] = b_quot[0];
    end

    logic               c_vld;
    prt_pkg::c_side_t   c_side;
    logic [1:0][NW-1:0] c_quot;
    logic [1:0][RW-1:0] c_rem;

    prt_divider #(
        .LANES (2),
        .DW    (NW),
        .VW    (RW),
        .SW    ($bits(prt_pkg::c_side_t))
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld),
        .in_side   (c_in),
        .dividend  (c_num),
        .divisor   (c_den),
        .out_valid (c_vld),
        .out_side  (c_side),
        .quot      (c_quot),
        .rem       (c_rem)
    );

    // ---------------- products ----------------
    logic [2:0][NW-1:0] mx, my;
    logic [2:0][NW-1:0] ad;
    logic [NW-1:0]      pc_w, pr_w, bz_w, e1r_w, e2r_w;

    assign pc_w  = NW'(c_side.bs.pc);
    assign pr_w  = NW'(c_side.bs.pr);
    assign bz_w  = NW'(g3z_reg);
    assign e1r_w = NW'(c_rem[0]);
    assign e2r_w = NW'(c_rem[1]);

    always_comb
    begin
        mx = '0;
        my = '0;
        ad = '0;
        case (c_side.bs.base.func)
            prt_pkg::FN_RANK_X:
            begin
                mx[0] = c_side.d1r; my[0] = nc_reg[NW-1:0];
                mx[1] = c_side.d1q; my[1] = bz_w;
                mx[2] = c_side.d2r; my[2] = c_side.bs.ncpc;
                ad[0] = c_side.d2q;
            end
            prt_pkg::FN_RANK_Y:
            begin
                mx[0] = NW'(c_side.bs.base.cx); my[0] = NW'(g2z_reg);
                mx[1] = c_side.d2r;             my[1] = bz_w;
                ad[0] = c_side.d2q;
            end
            prt_pkg::FN_RANK_Z:
            begin
                mx[0] = c_side.d2r; my[0] = pc_w;
                mx[1] = c_side.d1q; my[1] = bz_w;
                mx[2] = c_side.d2q; my[2] = c_side.bs.span[NW-1:0];
                ad[0] = c_side.d1r;
            end
            prt_pkg::FN_TUPLE_X:
            begin
                mx[0] = c_quot[0]; my[0] = pc_w;
                mx[1] = e1r_w;     my[1] = pr_w;
                ad[0] = e2r_w;
                ad[1] = c_quot[1];
            end
            prt_pkg::FN_TUPLE_Y:
            begin
                mx[1] = e1r_w; my[1] = pr_w;
                ad[1] = c_quot[0];
                ad[2] = c_side.d1q;
            end
            prt_pkg::FN_TUPLE_Z:
            begin
                mx[0] = c_quot[0];  my[0] = pc_w;
                mx[1] = c_side.d1q; my[1] = pr_w;
                ad[0] = c_side.d3r;
                ad[1] = c_quot[1];
            end
            default: ;
        endcase
    end

    logic [2:0][NW-1:0] m_prod_reg;
    logic [2:0][NW-1:0] m_add_reg;
    prt_pkg::func_t     m_func_reg;
    prt_pkg::err_t      m_err_reg;
    logic               m_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_prod_reg[i] <= mul_lo(mx[i], my[i]);
            end
            m_add_reg  <= ad;
            m_func_reg <= c_side.bs.base.func;
            m_err_reg  <= c_side.bs.base.err;
            m_zero_reg <= c_side.bs.base.zero;
        end
    end

    // ---------------- final sums and output register ----------------
    logic [NW-1:0] sum_rank, sum0, sum1;
    logic [NW-1:0] res_rank;
    logic [CW-1:0] res_x, res_y, res_z;
    logic [63:0]   out_next;
    logic [63:0]   out_data_reg;

    assign sum_rank = m_prod_reg[0] + m_prod_reg[1] + m_prod_reg[2] + m_add_reg[0];
    assign sum0     = m_prod_reg[0] + m_add_reg[0];
    assign sum1     = m_prod_reg[1] + m_add_reg[1];

    always_comb
    begin
        res_rank = '0;
        res_x    = '0;
        res_y    = '0;
        res_z    = '0;
        case (m_func_reg)
            prt_pkg::FN_RANK_X, prt_pkg::FN_RANK_Y, prt_pkg::FN_RANK_Z:
                res_rank = sum_rank;
            prt_pkg::FN_TUPLE_X:
            begin
                res_y = sum0[CW-1:0];
                res_z = sum1[CW-1:0];
            end
            prt_pkg::FN_TUPLE_Y:
            begin
                res_x = m_add_reg[2][CW-1:0];
                res_z = sum1[CW-1:0];
            end
            prt_pkg::FN_TUPLE_Z:
            begin
                res_x = sum1[CW-1:0];
                res_y = sum0[CW-1:0];
            end
            default: ;
        endcase
        if (m_zero_reg)
        begin
            res_rank = '0;
            res_x    = '0;
            res_y    = '0;
            res_z    = '0;
        end
        out_next = {2'b00, m_err_reg, res_z, res_y, res_x, res_rank};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_en)
            out_vld_reg <= m_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
            out_data_reg <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

>>> design/prt_checker.sv
// Port-level checks of the pencil rank/tuple mapper and their bind.
`default_nettype none
module prt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an empty output side never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[61:60] != 2'd3)
        else $error("undefined error code");

    // an error result carries no rank or coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[61:60] != 2'd0 |-> m_tdata[59:0] == 60'd0)
        else $error("error result with nonzero payload");

endmodule

bind pencil_rank_tuple_mapper_unit prt_checker u_prt_checker (.*);
`default_nettype wire

>>> dv/tb_pencil_rank_tuple_mapper_unit.sv
// Self-checking testbench for the pencil rank/tuple mapper: directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_pencil_rank_tuple_mapper_unit;

    // One result item as it leaves the block.
    typedef struct {
        logic [23:0] rank;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] z;
        logic [1:0]  err;
    } map_res_t;

    // One row of the directed table; typed rows carry a hand-written result.
    typedef struct {
        logic [2:0]  fn;
        logic [23:0] rk;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] cz;
        bit          typed;
        map_res_t    res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    // Local copy of the six grid registers.
    logic [12:0] g2 [3];
    logic [12:0] g3 [3];

    map_res_t pending_maps [$];
    int       mismatches;
    int       tx_idle;
    int       rx_idle;
    bit       hold_go;
    bit       hold_done;
    int       hold_left;

    pencil_rank_tuple_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Compute the rank or tuple the block should produce for one item.
    function automatic map_res_t map_lookup(logic [2:0] fn, logic [23:0] rk,
                                            logic [11:0] cx, logic [11:0] cy,
                                            logic [11:0] cz);
        map_res_t    o;
        logic [63:0] p [3];
        logic [63:0] b [3];
        logic [63:0] c [3];
        logic [63:0] r, pc, pr, nc, rep, lo, span, res, ox, oy, oz;
        int          ax, ci, ri;
        logic [1:0]  e;
        o = '{default: '0};
        res = 0; ox = 0; oy = 0; oz = 0; pc = 0; pr = 0;
        e = prt_pkg::ERR_NONE;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = g2[i];
            b[i] = g3[i];
        end
        c[0] = cx; c[1] = cy; c[2] = cz;
        r = rk;
        if (fn > prt_pkg::FN_TUPLE_Z)
            return o;
        ax = (fn < prt_pkg::FN_TUPLE_X) ? int'(fn) : int'(fn) - 3;
        ci = (ax == 1) ? 0 : 1;
        ri = (ax == 2) ? 0 : 2;
        if (fn >= prt_pkg::FN_TUPLE_X && p[ax] != 1)
            e = prt_pkg::ERR_EXTENT;
        else if (b[0] == 0 || b[1] == 0 || b[2] == 0)
            e = prt_pkg::ERR_RATIO;
        else
        begin
            pc = p[ci] / b[ci];
            pr = p[ri] / b[ri];
            if (pc == 0 || pr == 0)
                e = prt_pkg::ERR_RATIO;
        end
        if (e == prt_pkg::ERR_NONE)
        begin
            case (fn)
                prt_pkg::FN_RANK_X:
                begin
                    nc = b[2] * b[1];
                    res = (c[1] % pc) * nc + (c[1] / pc) * b[2]
                        + (c[2] % pr) * nc * pc + c[2] / pr;
                end
                prt_pkg::FN_RANK_Y:
                    res = c[0] * p[2] + (c[2] % pr) * b[2] + c[2] / pr;
                prt_pkg::FN_RANK_Z:
                    res = (c[1] % pc) + (c[1] / pc) * b[2]
                        + (c[0] % pr) * pc + (c[0] / pr) * p[1] * pr;
                prt_pkg::FN_TUPLE_X:
                begin
                    nc = b[2] * b[1];
                    rep = r / nc;
                    lo = r - rep * nc;
                    oy = (lo / b[2]) * pc + rep % pc;
                    oz = (lo % b[2]) * pr + rep / pc;
                end
                prt_pkg::FN_TUPLE_Y:
                begin
                    lo = r % p[2];
                    ox = r / p[2];
                    oz = lo / b[2] + (lo % b[2]) * pr;
                end
                default:
                begin
                    span = p[1] * pr;
                    ox = (r / span) * pr + (r % b[2]) / pc;
                    oy = ((r % span) / b[2]) * pc + r % pc;
                end
            endcase
        end
        o.rank = res[23:0];
        o.x    = ox[11:0];
        o.y    = oy[11:0];
        o.z    = oz[11:0];
        o.err  = e;
        return o;
    endfunction

    // Write one grid register and mirror it locally; only called while idle.
    // The caller drops cfg_valid after the last write of a batch.
    task automatic write_grid(prt_pkg::cfg_idx_t idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx < prt_pkg::CFG_GRID3D_X)
            g2[idx] = val;
        else
            g3[idx - prt_pkg::CFG_GRID3D_X] = val;
    endtask

    // Offer one item with random leading gaps; queue its result on acceptance.
    task automatic send_map(logic [2:0] fn, logic [23:0] rk, logic [11:0] cx,
                            logic [11:0] cy, logic [11:0] cz, bit typed,
                            map_res_t res);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'd0, cz, cy, cx, rk};
        do @(posedge clk); while (!s_tready);
        pending_maps.push_back(typed ? res : map_lookup(fn, rk, cx, cy, cz));
    endtask

    // Hold off until every result is back, then let the pipe drain fully.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Pick a grid value: mostly small, sometimes the extremes or out of range.
    function automatic logic [12:0] pick_grid(bit may_zero);
        int k;
        k = $urandom_range(15);
        if (k == 0)
            return 13'd4096;
        if (k == 1 && may_zero)
            return 13'd0;
        if (k == 2)
            return 13'($urandom_range(8191));
        return 13'($urandom_range(1, 12));
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_go && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        map_res_t want;
        map_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rank = m_tdata[23:0];
            got.x    = m_tdata[35:24];
            got.y    = m_tdata[47:36];
            got.z    = m_tdata[59:48];
            got.err  = m_tdata[61:60];
            if (pending_maps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (got.rank !== want.rank || got.x !== want.x || got.y !== want.y
                    || got.z !== want.z || got.err !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp rank %h x %h y %h z %h err %0d,",
                                  " got rank %h x %h y %h z %h err %0d"},
                                 want.rank, want.x, want.y, want.z, want.err,
                                 got.rank, got.x, got.y, got.z, got.err);
                end
            end
        end
    end

    // Limit on the whole run.
    initial
    begin
        #(12 * 1000000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        dir_row_t    dir [12];
        map_res_t    zero_res;
        logic [2:0]  fn;
        logic [23:0] rk;
        int          ax;
        zero_res = '{default: '0};
        mismatches = 0;
        hold_go = 1'b0;
        tx_idle = 11;
        rx_idle = 52;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        for (int i = 0; i < 3; i++)
        begin
            g2[i] = 13'd1;
            g3[i] = 13'd1;
        end

        // With every grid register at one, rank is a sum of coordinates and
        // the tuple takes the rank straight through on the free axis.
        dir[0]  = '{prt_pkg::FN_RANK_X, 24'd0, 12'hFFF, 12'hFFF, 12'hFFF, 1,
                    '{24'd8190, 12'd0, 12'd0, 12'd0, prt_pkg::ERR_NONE}};
        dir[1]  = '{prt_pkg::FN_RANK_X, 24'hFFFFFF, 12'd0, 12'd0, 12'd0, 1, zero_res};
        dir[2]  = '{prt_pkg::FN_RANK_Y, 24'd0, 12'hFFF, 12'd0, 12'hFFF, 0, zero_res};
        dir[3]  = '{prt_pkg::FN_RANK_Z, 24'd0, 12'hFFF, 12'hFFF, 12'd0, 0, zero_res};
        dir[4]  = '{prt_pkg::FN_TUPLE_X, 24'hFFFFFF, 12'd0, 12'd0, 12'd0, 1,
                    '{24'd0, 12'd0, 12'd0, 12'hFFF, prt_pkg::ERR_NONE}};
        dir[5]  = '{prt_pkg::FN_TUPLE_X, 24'd0, 12'hFFF, 12'hFFF, 12'hFFF, 1, zero_res};
        dir[6]  = '{prt_pkg::FN_TUPLE_Y, 24'hFFFFFF, 12'd0, 12'd0, 12'd0, 0, zero_res};
        dir[7]  = '{prt_pkg::FN_TUPLE_Y, 24'd0, 12'd0, 12'd0, 12'd0, 1, zero_res};
        dir[8]  = '{prt_pkg::FN_TUPLE_Z, 24'hABCDEF, 12'd0, 12'd0, 12'd0, 0, zero_res};
        dir[9]  = '{prt_pkg::FN_TUPLE_Z, 24'd0, 12'd0, 12'd0, 12'd0, 0, zero_res};
        dir[10] = '{3'd6, 24'hFFFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1, zero_res};
        dir[11] = '{3'd7, 24'h555555, 12'hAAA, 12'h555, 12'hAAA, 1, zero_res};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send_map(dir[i].fn, dir[i].rk, dir[i].cx, dir[i].cy, dir[i].cz,
                     dir[i].typed, dir[i].res);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                tx_idle = 52;
                rx_idle = 11;
            end
            if (ph == 4)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            // Place the pencil on one axis in most phases: extent one there, blocks
            // mostly small elsewhere, so most items map cleanly.
            ax = $urandom_range(2);
            for (int i = 0; i < 3; i++)
            begin
                if (ph == 1)
                begin
                    write_grid(prt_pkg::cfg_idx_t'(i), (i == ax) ? 13'd1 : 13'd4096);
                    write_grid(prt_pkg::cfg_idx_t'(i + 3), 13'd4096);
                end
                else if (ph == 5)
                begin
                    write_grid(prt_pkg::cfg_idx_t'(i), 13'h1FFF);
                    write_grid(prt_pkg::cfg_idx_t'(i + 3),
                               (i == 2) ? 13'd0 : 13'h1FFF);
                end
                else
                begin
                    write_grid(prt_pkg::cfg_idx_t'(i),
                               (i == ax && $urandom_range(7) != 0)
                               ? 13'd1 : pick_grid(1'b0));
                    write_grid(prt_pkg::cfg_idx_t'(i + 3), ($urandom_range(3) == 0)
                                                           ? pick_grid(1'b1)
                                                           : 13'($urandom_range(1, 3)));
                end
            end
            cfg_valid <= 1'b0;

            for (int n = 0; n < 75; n++)
            begin
                // Stall the output for a long stretch so the pipe fills up.
                if (ph == 3 && n == 10)
                    hold_go = 1'b1;
                // Pause the input until every result is back.
                if (ph == 4 && n == 40)
                begin
                    s_tvalid <= 1'b0;
                    while (pending_maps.size() != 0)
                        @(posedge clk);
                end
                fn = ($urandom_range(15) == 0)
                     ? 3'($urandom_range(6, 7))
                     : 3'($urandom_range(prt_pkg::FN_RANK_X, prt_pkg::FN_TUPLE_Z));
                rk = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(255));
                send_map(fn, rk, 12'($urandom), 12'($urandom), 12'($urandom),
                         1'b0, zero_res);
            end
            drain();
        end

        if (mismatches == 0 && pending_maps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
